### src/assert_macros.svh
// assertion macros shared by the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### src/asf_pkg.sv
// types, constants and the crc step for the sample framer
`timescale 1ns / 1ps

package asf_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hFA;
	localparam logic [7:0]  SYNC_SECOND = 8'hCE;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  FLAG_OVERRUN = 8'h01;
	localparam logic [7:0]  FLAG_NONE    = 8'h00;

	// item kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// register indexes on the config port
	localparam logic REG_WATERMARK   = 1'b0;
	localparam logic REG_MAX_SAMPLES = 1'b1;

	// command queue geometry
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// configuration seen by the front end
	typedef struct packed {
		logic [4:0] watermark;
		logic [5:0] max_samples;
	} cfg_t;

	// six bytes to send, byte 0 in the low bits
	typedef struct packed {
		logic        start;
		logic        last;
		logic [47:0] bytes;
	} cmd_t;

	// one byte through the crc16-ccitt, msb first
	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

### src/accel_sample_framer_unit.sv
// top level of the accelerometer sample framer with its config registers
`timescale 1ns / 1ps

// Frames accelerometer samples into a byte stream. A status item arriving
// with no frame open and an entry count nonzero and at least the watermark
// opens a frame of min(entries, max_samples) samples (max_samples clamped to
// 1..FRAME_SAMPLES_MAX) and yields the six header bytes; each sample item in
// the frame yields six little-endian bytes, and the closing sample adds the
// crc16-ccitt (low byte first, frame_end on the high byte). The output side
// sends one byte per cycle while byte_stall is low, and that byte serializer
// sets the sustained rate; a header or a sample is six bytes, the closing one eight.
// Input items are taken one per cycle while the four-entry command queue
// between classifier and serializer has room; items yielding no bytes still
// pass one transfer. No clearing pass: items are taken right after reset.
module accel_sample_framer_unit #(
	parameter int FRAME_SAMPLES_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channel
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        kind,
	input  logic [7:0]  status_byte,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	// byte channel
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);
	import asf_pkg::*;

	cfg_t cfg_q;
	logic cfg_write;
	logic reg_index;

	logic cmd_push;
	cmd_t push_cmd;
	logic cmd_full;
	logic cmd_pop;
	cmd_t pop_cmd;
	logic cmd_avail;

	// config registers
	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watermark   <= 5'd16;
			cfg_q.max_samples <= 6'd32;
		end else if (cfg_write) begin
			case (reg_index)
				REG_WATERMARK:   cfg_q.watermark   <= pwdata[4:0];
				REG_MAX_SAMPLES: cfg_q.max_samples <= pwdata[5:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_index)
			REG_WATERMARK:   prdata = {27'd0, cfg_q.watermark};
			REG_MAX_SAMPLES: prdata = {26'd0, cfg_q.max_samples};
			default:         prdata = 32'd0;
		endcase
	end

	asf_front #(
		.FRAME_SAMPLES_MAX(FRAME_SAMPLES_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.kind         (kind),
		.status_byte  (status_byte),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.cmd_push     (cmd_push),
		.cmd          (push_cmd),
		.cmd_full     (cmd_full)
	);

	asf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.pop_cmd  (pop_cmd),
		.nonempty (cmd_avail)
	);

	asf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (cmd_avail),
		.cmd        (pop_cmd),
		.cmd_pop    (cmd_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule

### src/asf_front.sv
// front end: classifies items, tracks frame state and issues byte commands
`timescale 1ns / 1ps

module asf_front #(
	parameter int FRAME_SAMPLES_MAX = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  asf_pkg::cfg_t cfg,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  logic          kind,
	input  logic [7:0]    status_byte,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic          cmd_push,
	output asf_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import asf_pkg::*;

	localparam logic [5:0] LIMIT_MAX = 6'(FRAME_SAMPLES_MAX);

	logic        frame_open_q;
	logic [5:0]  samples_left_q;
	logic [15:0] sequence_q;
	logic [5:0]  frame_count_q;

	logic       accept;
	logic [5:0] entries;
	logic [5:0] limit;
	logic [5:0] n;
	logic       open_frame;
	logic       take_sample;
	logic       last_sample;

	// input transfer whenever the queue has room
	assign sample_stall = cmd_full;
	assign accept       = sample_valid && !cmd_full;

	// frame size from entry count and clamped maximum
	always_comb begin
		entries = status_byte[5:0];
		if (cfg.max_samples == 6'd0) begin
			limit = 6'd1;
		end else if (cfg.max_samples > LIMIT_MAX) begin
			limit = LIMIT_MAX;
		end else begin
			limit = cfg.max_samples;
		end
		n = (entries < limit) ? entries : limit;
	end

	// classification
	assign open_frame  = (kind == KIND_STATUS) && !frame_open_q && (entries != 6'd0)
		&& (entries >= {1'b0, cfg.watermark});
	assign take_sample = (kind == KIND_SAMPLE) && frame_open_q;
	assign last_sample = (samples_left_q == 6'd1);

	// command build
	always_comb begin
		cmd.start = open_frame;
		cmd.last  = take_sample && last_sample;
		if (open_frame) begin
			cmd.bytes = {(status_byte[7] ? FLAG_OVERRUN : FLAG_NONE), {2'b00, n},
				sequence_q[15:8], sequence_q[7:0], SYNC_SECOND, SYNC_FIRST};
		end else begin
			cmd.bytes = {accel_z, accel_y, accel_x};
		end
	end

	assign cmd_push = accept && (open_frame || take_sample);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q   <= 1'b0;
			samples_left_q <= 6'd0;
			sequence_q     <= 16'd0;
			frame_count_q  <= 6'd0;
		end else if (accept) begin
			if (open_frame) begin
				frame_open_q   <= 1'b1;
				samples_left_q <= n;
				frame_count_q  <= n;
			end else if (take_sample) begin
				samples_left_q <= samples_left_q - 6'd1;
				if (last_sample) begin
					frame_open_q <= 1'b0;
					sequence_q   <= sequence_q + {10'd0, frame_count_q};
				end
			end
		end
	end

endmodule

### src/asf_cmd_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asf_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  asf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output asf_pkg::cmd_t pop_cmd,
	output logic          nonempty
);
	import asf_pkg::*;

	cmd_t                 entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign full     = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_cmd  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CMD_CNT_W'(1);
				2'b01:   count_q <= count_q - CMD_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !full)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, nonempty)
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CMD_CNT_W'(CMD_DEPTH))

endmodule

### src/asf_back.sv
// back end: serializes commands into bytes and appends the frame crc
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_avail,
	input  asf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          byte_valid,
	input  logic          byte_stall,
	output logic [7:0]    frame_byte,
	output logic          frame_end
);
	import asf_pkg::*;

	cmd_t        cur_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        end_q;

	logic        advance;
	logic        done;
	logic [2:0]  final_idx;
	logic [7:0]  sel_byte;
	logic [15:0] crc_base;

	// output register frees up when empty or taken
	assign advance   = !out_valid_q || !byte_stall;
	assign final_idx = cur_q.last ? 3'd7 : 3'd5;
	assign done      = busy_q && advance && (idx_q == final_idx);
	assign cmd_pop   = cmd_avail && (!busy_q || done);

	// byte select: six payload bytes then crc low and high
	always_comb begin
		case (idx_q)
			3'd0:    sel_byte = cur_q.bytes[7:0];
			3'd1:    sel_byte = cur_q.bytes[15:8];
			3'd2:    sel_byte = cur_q.bytes[23:16];
			3'd3:    sel_byte = cur_q.bytes[31:24];
			3'd4:    sel_byte = cur_q.bytes[39:32];
			3'd5:    sel_byte = cur_q.bytes[47:40];
			3'd6:    sel_byte = crc_q[7:0];
			default: sel_byte = crc_q[15:8];
		endcase
	end

	// crc restarts on the first header byte
	assign crc_base = (cur_q.start && (idx_q == 3'd0)) ? CRC_INIT : crc_q;

	// sequencer and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (done) begin
				busy_q <= 1'b0;
				idx_q  <= 3'd0;
			end else if (busy_q && advance) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// payload, crc and current command
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (busy_q && advance) begin
			byte_q <= sel_byte;
			end_q  <= (idx_q == 3'd7);
			if (idx_q < 3'd6) begin
				crc_q <= crc_feed(crc_base, sel_byte);
			end
		end
	end

	assign byte_valid = out_valid_q;
	assign frame_byte = byte_q;
	assign frame_end  = end_q;

	`ASSERT_IMPLIES(a_crc_only_on_last, clk, arst_n, busy_q && (idx_q > 3'd5), cur_q.last)
	`ASSERT_NEVER(a_header_not_last, clk, arst_n, busy_q && cur_q.start && cur_q.last)
	`ASSERT_NEXT(a_end_after_crc_high, clk, arst_n, busy_q && advance && (idx_q == 3'd7),
		byte_valid && frame_end)

endmodule
